// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hpt_pkg.sv
`default_nettype none

package hpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int REG_W     = 2 * COORD_W;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [REG_W-1:0]          cfg_reg_t;

  // Load strobes of the three register stages after the input stage.
  typedef struct packed {
    logic ld_prod;
    logic ld_pair;
    logic ld_out;
  } hpt_load_t;

  localparam cfg_reg_t ONE_LO = cfg_reg_t'(1) << FRAC_BITS;
  localparam cfg_reg_t ONE_HI = cfg_reg_t'(1) << (FRAC_BITS + COORD_W);

endpackage

`default_nettype wire

// File: sv/hpt_row.sv
`default_nettype none

module hpt_row (
  input  wire logic              clk,
  input  wire hpt_pkg::hpt_load_t load,
  input  wire hpt_pkg::coord_t   point [4],
  input  wire hpt_pkg::cfg_reg_t coef_lo,
  input  wire hpt_pkg::cfg_reg_t coef_hi,
  output hpt_pkg::coord_t        result,
  output logic                   ovf
);
  import hpt_pkg::*;

  coord_t                    coef [4];
  logic signed [PROD_W-1:0]  prod [4];
  logic signed [PAIR_W-1:0]  pair [2];
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   shifted;
  logic                      fits;

  assign coef[0] = coord_t'(coef_lo[COORD_W-1:0]);
  assign coef[1] = coord_t'(coef_lo[REG_W-1:COORD_W]);
  assign coef[2] = coord_t'(coef_hi[COORD_W-1:0]);
  assign coef[3] = coord_t'(coef_hi[REG_W-1:COORD_W]);

  always_ff @(posedge clk) begin
    if (load.ld_prod) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= PROD_W'(coef[c]) * PROD_W'(point[c]);
      end
    end
    if (load.ld_pair) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (load.ld_out) begin
      result <= fits ? coord_t'(shifted[COORD_W-1:0])
                     : (sum[SUM_W-1] ? coord_t'({1'b1, {(COORD_W-1){1'b0}}})
                                     : coord_t'({1'b0, {(COORD_W-1){1'b1}}}));
      ovf    <= !fits;
    end
  end

  // The arithmetic shift of the exact sum is the floor of the quotient.
  always_comb begin
    sum     = SUM_W'(pair[0]) + SUM_W'(pair[1]);
    shifted = sum >>> FRAC_BITS;
    fits    = (&shifted[SUM_W-1:COORD_W-1]) || !(|shifted[SUM_W-1:COORD_W-1]);
  end

endmodule

`default_nettype wire

// File: sv/homogeneous_point_transform.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_ready    | in_x, in_y, in_z, in_w, in_last
// output   | out_valid / out_ready  | out_x, out_y, out_z, out_w, out_overflow,
//          |                        | out_last
// config   | cfg_write (no wait)    | cfg_index, cfg_data
//
// One point per clock is accepted unless the output stalls; out_valid rises when
// the point reaches the row-sum stage (input register, product, pair-sum, row-sum).
// The sixteen 32x32 multipliers in the product stage set the clock period.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated.
// Reset clears all stage valid bits and loads the identity matrix.
`default_nettype none

`include "assert_macros.svh"

module homogeneous_point_transform (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hpt_pkg::coord_t            in_x,
  input  wire hpt_pkg::coord_t            in_y,
  input  wire hpt_pkg::coord_t            in_z,
  input  wire hpt_pkg::coord_t            in_w,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hpt_pkg::coord_t                 out_x,
  output hpt_pkg::coord_t                 out_y,
  output hpt_pkg::coord_t                 out_z,
  output hpt_pkg::coord_t                 out_w,
  output logic                            out_overflow,
  output logic                            out_last,
  input  wire logic                       cfg_write,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire hpt_pkg::cfg_reg_t          cfg_data
);
  import hpt_pkg::*;

  cfg_reg_t  coef_reg [NUM_REGS];
  coord_t    point [4];
  logic      v1, v2, v3, v4;
  logic      last1, last2, last3, last4;
  logic      rdy1, rdy2, rdy3, rdy4;
  hpt_load_t load;
  coord_t    result [4];
  logic      ovf [4];

  // A stage can take an item when it is empty or its content moves on.
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign load.ld_prod = rdy2 && v1;
  assign load.ld_pair = rdy3 && v2;
  assign load.ld_out  = rdy4 && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_reg[0] <= ONE_LO;
      coef_reg[1] <= '0;
      coef_reg[2] <= ONE_HI;
      coef_reg[3] <= '0;
      coef_reg[4] <= '0;
      coef_reg[5] <= ONE_LO;
      coef_reg[6] <= '0;
      coef_reg[7] <= ONE_HI;
    end else if (cfg_write) begin
      coef_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      point[0] <= in_x;
      point[1] <= in_y;
      point[2] <= in_z;
      point[3] <= in_w;
      last1    <= in_last;
    end
    if (load.ld_prod) begin
      last2 <= last1;
    end
    if (load.ld_pair) begin
      last3 <= last2;
    end
    if (load.ld_out) begin
      last4 <= last3;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_row u_row (
      .clk     (clk),
      .load    (load),
      .point   (point),
      .coef_lo (coef_reg[2*r]),
      .coef_hi (coef_reg[2*r+1]),
      .result  (result[r]),
      .ovf     (ovf[r])
    );
  end

  assign out_valid    = v4;
  assign out_x        = result[0];
  assign out_y        = result[1];
  assign out_z        = result[2];
  assign out_w        = result[3];
  assign out_overflow = ovf[0] || ovf[1] || ovf[2] || ovf[3];
  assign out_last     = last4;

  `ASSERT_RUN(a_drain_frees_input, (out_valid && out_ready) |-> in_ready,
              "input not ready although the output is draining")
  `ASSERT_RUN(a_stalled_pair_held, (v3 && !rdy3) |=> v3,
              "pair-sum stage lost an item during a stall")
  `ASSERT_RUN(a_stalled_prod_held, (v2 && !rdy2) |=> (v2 && v3),
              "product stage lost an item during a stall")
  `ASSERT_ALL(a_reset_identity,
              rst |=> (coef_reg[0] == ONE_LO && coef_reg[7] == ONE_HI && !out_valid),
              "reset did not load the identity matrix or clear the pipeline")

endmodule

`default_nettype wire

// File: verif/homogeneous_point_transform_tb.sv
`default_nettype none

module homogeneous_point_transform_tb;
  import hpt_pkg::*;

  localparam int ACC_W       = 68;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;
  localparam int PRINT_CAP   = 50;
  localparam coord_t UNIT    = coord_t'(1) << FRAC_BITS;
  localparam coord_t C_MAX   = 32'sh7fffffff;
  localparam coord_t C_MIN   = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } matrix_reg_e;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
    logic   overflow;
    logic   last;
  } point_result_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  coord_t   in_x = '0;
  coord_t   in_y = '0;
  coord_t   in_z = '0;
  coord_t   in_w = '0;
  logic     in_last = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  coord_t   out_x;
  coord_t   out_y;
  coord_t   out_z;
  coord_t   out_w;
  logic     out_overflow;
  logic     out_last;
  logic     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cfg_reg_t cfg_data = '0;

  cfg_reg_t      matrix_regs [NUM_REGS];
  point_result_t transformed_q [$];
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            back_to_back = 1'b0;

  homogeneous_point_transform u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_w         (in_w),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_overflow (out_overflow),
    .out_last     (out_last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The register file comes out of reset holding the identity matrix.
  initial begin
    matrix_regs[REG_ROW0_COLS01] = ONE_LO;
    matrix_regs[REG_ROW0_COLS23] = '0;
    matrix_regs[REG_ROW1_COLS01] = ONE_HI;
    matrix_regs[REG_ROW1_COLS23] = '0;
    matrix_regs[REG_ROW2_COLS01] = '0;
    matrix_regs[REG_ROW2_COLS23] = ONE_LO;
    matrix_regs[REG_ROW3_COLS01] = '0;
    matrix_regs[REG_ROW3_COLS23] = ONE_HI;
  end

  function automatic coord_t coefficient(input int r, input int c);
    cfg_reg_t word;
    word = matrix_regs[2 * r + c / 2];
    return (c % 2 == 1) ? word[63:32] : word[31:0];
  endfunction

  // Sums the four products of each row exactly, floors the shift and clamps.
  function automatic point_result_t transform_point(input coord_t pt [4], input logic last);
    point_result_t res;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] fit;
    coord_t comp [4];
    res.overflow = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        a = ACC_W'(coefficient(r, c));
        b = ACC_W'(pt[c]);
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      fit = ACC_W'($signed(acc[31:0]));
      if (acc != fit) begin
        res.overflow = 1'b1;
        comp[r] = (acc < 0) ? C_MIN : C_MAX;
      end else begin
        comp[r] = acc[31:0];
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    res.last = last;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    point_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (transformed_q.size() == 0) begin
        report_mismatch("result transfer with no point outstanding");
      end else begin
        want = transformed_q.pop_front();
        compare_field("out_x", out_x, want.x);
        compare_field("out_y", out_y, want.y);
        compare_field("out_z", out_z, want.z);
        compare_field("out_w", out_w, want.w);
        compare_field("out_overflow", 32'(out_overflow), 32'(want.overflow));
        compare_field("out_last", 32'(out_last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: random stalls between ready stretches, none once back_to_back is set.
  initial begin : sink_pacing
    int n;
    forever begin
      if (back_to_back) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = (($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12));
        repeat (n) @(posedge clk);
        if (!back_to_back) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end
  end

  // Leaves in_valid high on return so that a following point needs no second
  // assignment in the same step.
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input coord_t w, input logic last);
    coord_t pt [4];
    pt = '{x, y, z, w};
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_w     <= w;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transformed_q.push_back(transform_point(pt, last));
  endtask

  task automatic hold_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_matrix(input coord_t m [4][4]);
    matrix_reg_e idx;
    cfg_reg_t    data;
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        idx  = matrix_reg_e'(2 * r + h);
        data = {m[r][2 * h + 1], m[r][2 * h]};
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        matrix_regs[idx] = data;
      end
    end
    cfg_write <= 1'b0;
  endtask

  // Mostly modest coordinates within +-256.0; wild_pct of the draws are raw
  // bit patterns, zero or the extremes of the range.
  function automatic coord_t rand_value(input int wild_pct);
    int spread;
    if ($urandom_range(0, 99) < wild_pct) begin
      case ($urandom_range(0, 5))
        0:       return C_MIN;
        1:       return C_MAX;
        2:       return '0;
        default: return coord_t'($urandom);
      endcase
    end
    spread = $urandom_range(8, 24);
    return coord_t'($urandom_range(0, (1 << (spread + 1)) - 1)) - (coord_t'(1) << spread);
  endfunction

  task automatic send_random_point(input int wild_pct);
    coord_t w;
    w = ($urandom_range(0, 3) == 0) ? rand_value(wild_pct) : UNIT;
    send_point(rand_value(wild_pct), rand_value(wild_pct), rand_value(wild_pct), w,
               $urandom_range(0, 7) == 0);
  endtask

  task automatic test_reset_identity();
    send_point(2 * UNIT, -3 * UNIT, UNIT / 2, UNIT, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    send_point('0, '0, '0, '0, 1'b0);
    send_point(32'shAAAAAAAA, 32'sh55555555, 32'sh55555555, 32'shAAAAAAAA, 1'b1);
  endtask

  task automatic test_extreme_saturation();
    coord_t m [4][4];
    drain_results();
    foreach (m[r, c]) m[r][c] = C_MIN;
    load_matrix(m);
    // Four products of the most negative values sum to 2^64 before the shift.
    send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
    send_point('0, '0, '0, '0, 1'b0);
    drain_results();
    foreach (m[r, c]) m[r][c] = C_MAX;
    load_matrix(m);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, C_MAX, C_MIN, 1'b1);
    // Only one row saturates; the flag must still be raised.
    drain_results();
    foreach (m[r, c]) m[r][c] = (r == 0) ? C_MAX : ((r == c) ? UNIT : '0);
    load_matrix(m);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
  endtask

  task automatic test_floor_rounding();
    coord_t m [4][4];
    drain_results();
    foreach (m[r, c]) m[r][c] = '0;
    m[0][0] = 32'sd1;
    m[1][0] = UNIT / 2;
    for (int c = 0; c < 4; c++) begin
      m[2][c] = 32'sd1;
      m[3][c] = UNIT / 2;
    end
    load_matrix(m);
    // Negative fractions must round towards minus infinity, and the fraction
    // bits of the four products must carry into the sum.
    send_point(-32'sd1, -32'sd1, 32'sd1, 32'sd1, 1'b0);
    send_point(UNIT / 2, UNIT / 2, UNIT / 2, UNIT / 2, 1'b0);
    send_point(-UNIT / 2, UNIT / 2, -UNIT / 2, -32'sd1, 1'b1);
    send_point(-UNIT, 32'sd3, -32'sd7, UNIT - 1, 1'b0);
  endtask

  task automatic test_random_matrices();
    coord_t m [4][4];
    int gap_pct;
    int wild;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0:       wild = 0;
        1:       wild = 10;
        2:       wild = 40;
        default: wild = 100;
      endcase
      gap_pct = 10 * $urandom_range(0, 3);
      drain_results();
      foreach (m[r, c]) m[r][c] = rand_value(wild);
      load_matrix(m);
      for (int i = 0; i < 120; i++) begin
        // Once in the run the sender waits for the pipeline to empty completely.
        if (phase == 4 && i == 60)
          drain_results();
        else if ($urandom_range(0, 99) < gap_pct)
          hold_input($urandom_range(1, 9));
        send_random_point(wild);
      end
    end
  endtask

  task automatic test_back_to_back();
    coord_t m [4][4];
    drain_results();
    back_to_back = 1'b1;
    foreach (m[r, c]) m[r][c] = rand_value(10);
    load_matrix(m);
    for (int i = 0; i < 200; i++) send_random_point(10);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_identity();
    test_extreme_saturation();
    test_floor_rounding();
    test_random_matrices();
    test_back_to_back();
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/hpt_pkg.sv
sv/hpt_row.sv
sv/homogeneous_point_transform.sv
verif/homogeneous_point_transform_tb.sv
